@@ hw/rtl/spfc_pkg.sv @@
package spfc_pkg;

   // verdict codes on the status field
   typedef enum logic [2:0] {
      STATUS_ACCEPT      = 3'd0,
      STATUS_BAD_VERSION = 3'd1,
      STATUS_OTHER_APID  = 3'd2,
      STATUS_BAD_SUM     = 3'd3,
      STATUS_BEFORE      = 3'd4,
      STATUS_AFTER       = 3'd5,
      STATUS_TOO_SHORT   = 3'd6
   } status_type;

   // register indexes on the csr port
   typedef enum logic [2:0] {
      CSR_WANTED_APID = 3'd0,
      CSR_START_DAY   = 3'd1,
      CSR_START_MS    = 3'd2,
      CSR_END_DAY     = 3'd3,
      CSR_END_MS      = 3'd4
   } csr_index_type;

   localparam int unsigned CsrDataWidth = 27;

   // packet layout
   localparam int unsigned PriLastByte  = 5;
   localparam int unsigned TimeBytes    = 12;
   localparam int unsigned TimeKeptBytes = 8;
   // length field value under this means a data part under 14 bytes
   localparam logic [15:0] MinLenField  = 16'd13;

   // register reset values
   localparam logic [6:0]  ApidReset     = 7'd64;
   localparam logic [15:0] StartDayReset = 16'd0;
   localparam logic [26:0] StartMsReset  = 27'd0;
   localparam logic [21:0] EndDayReset   = 22'd4000000;
   localparam logic [26:0] EndMsReset    = 27'd90000000;

   // floor(x / 3) for x below 2**19 as (x * DivThreeMul) >> DivThreeShift
   localparam logic [17:0] DivThreeMul   = 18'd174763;
   localparam int unsigned DivThreeShift = 19;

endpackage

@@ hw/rtl/space_packet_filter_checksum_unit.sv @@
// Space packet filter: takes one byte of a back-to-back space packet stream per
// cycle and gives one verdict word at the last data byte of each packet, in the
// cycle after that byte is taken. Each packet is a 6-byte primary header and a
// data part of (length field + 1) bytes opening with a 12-byte time header;
// the payload after it is summed as packed big-endian 12-bit words and bits
// 15..4 of that sum are checked against the trailing 12-bit field; the packet is
// also checked for version 0 and length and filtered by APID and by the time window
// from the csr registers. The result register sits between the two sides, so bytes
// keep flowing while a verdict waits, and the input stalls only when a verdict is
// still held and a new one is due. Registers are to be written by the user only
// while the stream is idle; the block does not enforce this; csr_ready is always high.
module space_packet_filter_checksum_unit (
   input  logic                              clock,
   input  logic                              reset,
   // byte input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   // verdict output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic [10:0]                       rsp_packet_apid,
   output logic [13:0]                       rsp_packet_count,
   output logic [15:0]                       rsp_packet_days,
   output logic [31:0]                       rsp_packet_millisecond,
   output logic [15:0]                       rsp_packet_microsecond,
   output logic [11:0]                       rsp_computed_checksum,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [2:0]                        csr_index,
   input  logic [spfc_pkg::CsrDataWidth-1:0] csr_data
);
   import spfc_pkg::*;

   // registers
   logic [6:0]  wanted_apid_ff;
   logic [15:0] start_day_ff;
   logic [26:0] start_ms_ff;
   logic [21:0] end_day_ff;
   logic [26:0] end_ms_ff;

   // parse state
   logic        in_data_ff;
   logic [2:0]  hdr_cnt_ff;
   logic [15:0] d_ff;
   logic [15:0] len_ff;
   logic        short_ff;
   logic [39:0] pri_ff;
   logic [63:0] time_ff;
   logic [15:0] sum_ff;
   logic [15:0] nsum_ff;
   logic [7:0]  part_ff;
   logic [1:0]  phase_ff;
   logic [3:0]  nib_ff;
   logic [15:0] limit_ff;

   // result register
   logic        rsp_valid_ff;
   status_type  status_ff;
   logic [10:0] apid_ff;
   logic [13:0] count_ff;
   logic [15:0] days_ff;
   logic [31:0] ms_ff;
   logic [15:0] us_ff;
   logic [11:0] chk_ff;

   logic        accept_w;
   logic        last_w;
   logic        emit_w;

   // handshakes
   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall & last_w;
   assign accept_w  = req_valid & ~req_stall;
   assign last_w    = in_data_ff & (d_ff == len_ff);
   assign emit_w    = accept_w & last_w;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_apid_ff <= ApidReset;
         start_day_ff   <= StartDayReset;
         start_ms_ff    <= StartMsReset;
         end_day_ff     <= EndDayReset;
         end_ms_ff      <= EndMsReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WANTED_APID: wanted_apid_ff <= csr_data[6:0];
            CSR_START_DAY:   start_day_ff   <= csr_data[15:0];
            CSR_START_MS:    start_ms_ff    <= csr_data[26:0];
            CSR_END_DAY:     end_day_ff     <= csr_data[21:0];
            CSR_END_MS:      end_ms_ff      <= csr_data[26:0];
            default: ;
         endcase
      end
   end

   // word limit: floor((2 * payload - 3) / 3), payload = len + 1 - 12
   logic [17:0] lim_x_w;
   logic [35:0] lim_prod_w;
   assign lim_x_w    = {1'b0, len_ff, 1'b0} - 18'd25;
   assign lim_prod_w = lim_x_w * DivThreeMul;

   always_ff @(posedge clock) begin
      limit_ff <= lim_prod_w[DivThreeShift +: 16];
   end

   // time header with the current byte merged in
   logic [63:0] time_in;
   always_comb begin
      time_in = time_ff;
      if (!in_data_ff) begin
         if (hdr_cnt_ff == 3'd0) begin
            time_in = '0;
         end
      end else if (d_ff < 16'(TimeKeptBytes)) begin
         for (int i = 0; i < TimeKeptBytes; i++) begin
            if (d_ff[2:0] == 3'(i)) begin
               time_in[63 - 8*i -: 8] = req_data_byte;
            end
         end
      end
   end

   // payload word assembly
   logic        pay_w;
   logic        add_w;
   logic [11:0] word_w;
   assign pay_w = in_data_ff & ~short_ff & (d_ff >= 16'(TimeBytes));
   always_comb begin
      word_w = '0;
      add_w  = 1'b0;
      case (phase_ff)
         2'd1: begin
            word_w = {part_ff, req_data_byte[7:4]};
            add_w  = pay_w;
         end
         2'd2: begin
            word_w = {part_ff[3:0], req_data_byte};
            add_w  = pay_w;
         end
         default: ;
      endcase
      if (nsum_ff >= limit_ff) begin
         add_w = 1'b0;
      end
   end

   // parse state update
   always_ff @(posedge clock) begin
      if (reset) begin
         in_data_ff <= 1'b0;
         hdr_cnt_ff <= '0;
         d_ff       <= '0;
         phase_ff   <= '0;
      end else if (accept_w) begin
         if (!in_data_ff) begin
            if (hdr_cnt_ff == 3'(PriLastByte)) begin
               hdr_cnt_ff <= '0;
               in_data_ff <= 1'b1;
            end else begin
               hdr_cnt_ff <= hdr_cnt_ff + 3'd1;
            end
            d_ff     <= '0;
            phase_ff <= '0;
         end else if (last_w) begin
            in_data_ff <= 1'b0;
            d_ff       <= '0;
         end else begin
            d_ff <= d_ff + 16'd1;
            if (pay_w) begin
               phase_ff <= (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
            end
         end
      end
   end

   // parse datapath
   always_ff @(posedge clock) begin
      if (accept_w) begin
         time_ff <= time_in;
         if (!in_data_ff) begin
            if (hdr_cnt_ff == 3'(PriLastByte)) begin
               len_ff   <= {pri_ff[7:0], req_data_byte};
               short_ff <= {pri_ff[7:0], req_data_byte} < MinLenField;
            end else begin
               pri_ff <= {pri_ff[31:0], req_data_byte};
            end
            if (hdr_cnt_ff == 3'd0) begin
               sum_ff  <= '0;
               nsum_ff <= '0;
               part_ff <= '0;
            end
         end else begin
            nib_ff <= req_data_byte[3:0];
            if (pay_w) begin
               case (phase_ff)
                  2'd0:    part_ff <= req_data_byte;
                  2'd1:    part_ff <= {4'd0, req_data_byte[3:0]};
                  default: part_ff <= '0;
               endcase
            end
            if (add_w) begin
               sum_ff  <= sum_ff + {4'd0, word_w};
               nsum_ff <= nsum_ff + 16'd1;
            end
         end
      end
   end

   // verdict
   logic [2:0]  version_w;
   logic [10:0] apid_w;
   logic [13:0] count_w;
   logic [15:0] days_w;
   logic [31:0] ms_w;
   logic [15:0] us_w;
   logic [11:0] field_w;
   logic        before_w;
   logic        after_w;
   status_type  status_w;

   assign version_w = pri_ff[39:37];
   assign apid_w    = {pri_ff[34:32], pri_ff[31:24]};
   assign count_w   = {pri_ff[21:16], pri_ff[15:8]};
   assign days_w    = time_in[63:48];
   assign ms_w      = time_in[47:16];
   assign us_w      = time_in[15:0];
   assign field_w   = {nib_ff, req_data_byte};
   assign before_w  = (days_w < start_day_ff) ||
                      ((days_w == start_day_ff) && (ms_w < {5'd0, start_ms_ff}));
   assign after_w   = ({6'd0, days_w} > end_day_ff) ||
                      (({6'd0, days_w} == end_day_ff) && (ms_w >= {5'd0, end_ms_ff}));

   always_comb begin
      if (version_w != 3'd0) begin
         status_w = STATUS_BAD_VERSION;
      end else if (apid_w != {4'd0, wanted_apid_ff}) begin
         status_w = STATUS_OTHER_APID;
      end else if (short_ff) begin
         status_w = STATUS_TOO_SHORT;
      end else if (sum_ff[15:4] != field_w) begin
         status_w = STATUS_BAD_SUM;
      end else if (before_w) begin
         status_w = STATUS_BEFORE;
      end else if (after_w) begin
         status_w = STATUS_AFTER;
      end else begin
         status_w = STATUS_ACCEPT;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_w) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_w) begin
         status_ff <= status_w;
         apid_ff   <= apid_w;
         count_ff  <= count_w;
         if (version_w != 3'd0) begin
            days_ff <= '0;
            ms_ff   <= '0;
            us_ff   <= '0;
         end else begin
            days_ff <= days_w;
            ms_ff   <= ms_w;
            us_ff   <= us_w;
         end
         chk_ff <= ((version_w != 3'd0) || short_ff) ? 12'd0 : sum_ff[15:4];
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_packet_apid        = apid_ff;
   assign rsp_packet_count       = count_ff;
   assign rsp_packet_days        = days_ff;
   assign rsp_packet_millisecond = ms_ff;
   assign rsp_packet_microsecond = us_ff;
   assign rsp_computed_checksum  = chk_ff;

   // checks
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit_w |=> rsp_valid_ff && (status_ff == $past(status_w)))
      else $error("verdict not loaded at last data byte");

   a_hdr_index: assert property (@(posedge clock) disable iff (reset)
      !in_data_ff |-> (d_ff == 16'd0) && (hdr_cnt_ff <= 3'(PriLastByte)))
      else $error("header counter out of range");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("payload phase out of range");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

endmodule
